[hw/rtl/bps_pkg.sv]
// ============================================================================
// bps_pkg: shared types, constants and a function of the specular shader
// Holds the table geometry, the register indexes, the word types passed
// between the pipeline modules and the rounded Q1.15 multiply.
// ============================================================================
package bps_pkg;

    localparam int POW_DEPTH_LOG2  = 8;
    localparam int POW_TABLE_DEPTH = 1 << POW_DEPTH_LOG2;
    localparam int ADDR_W          = POW_DEPTH_LOG2 + 1;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_EXPONENT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_INTENSITY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_COLOR_RED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_COLOR_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_COLOR_BLUE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRESNEL_ENABLE   = 3'd5;

    typedef logic [2:0][15:0] t_vec3;
    typedef logic [2:0][15:0] t_rgb;

    typedef struct packed {
        logic en;
        logic valid;
    } t_flow;

    typedef struct packed {
        logic [15:0] exponent;
        logic [15:0] intensity;
        t_rgb        color;
        logic        fresnel;
    } t_cfg;

    typedef struct packed {
        logic spec_valid;
        t_rgb color;
    } t_res;

    function automatic logic [15:0] mulq15(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = {16'd0, a} * {16'd0, b} + 32'd16384;
        return p[30:15];
    endfunction

endpackage

[hw/rtl/bps_vec.sv]
// ============================================================================
// bps_vec: half vector products
// Forms H = L + V, the dot product H.N and the squared length H.H, and
// takes the magnitude of the dot product, over four register stages.
// ============================================================================
module bps_vec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bps_pkg::t_flow i_flow,
    input  bps_pkg::t_vec3 i_normal,
    input  bps_pkg::t_vec3 i_light,
    input  bps_pkg::t_vec3 i_view,
    input  bps_pkg::t_rgb  i_color,
    output logic           o_valid,
    output logic [32:0]    o_adot,
    output logic [33:0]    o_len2,
    output bps_pkg::t_rgb  o_color
);

    logic [3:0]          r_v;
    logic signed [16:0]  r_h [3];
    logic signed [15:0]  r_n [3];
    logic signed [32:0]  r_hn [3];
    logic [32:0]         r_hh [3];
    logic signed [34:0]  r_dot;
    logic [33:0]         r_len2;
    logic [32:0]         r_adot;
    logic [33:0]         r_len2_o;
    bps_pkg::t_rgb       r_c1, r_c2, r_c3, r_c4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_flow.en) begin
            r_v <= {r_v[2:0], i_flow.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            for (int k = 0; k < 3; k++) begin
                r_h[k]  <= $signed({i_light[k][15], i_light[k]})
                         + $signed({i_view[k][15], i_view[k]});
                r_n[k]  <= $signed(i_normal[k]);
                r_hn[k] <= r_h[k] * r_n[k];
                r_hh[k] <= r_h[k] * r_h[k];
            end
            r_dot    <= r_hn[0] + r_hn[1] + r_hn[2];
            r_len2   <= 34'(r_hh[0]) + 34'(r_hh[1]) + 34'(r_hh[2]);
            r_adot   <= r_dot[34] ? 33'(-r_dot) : r_dot[32:0];
            r_len2_o <= r_len2;
            r_c1     <= i_color;
            r_c2     <= r_c1;
            r_c3     <= r_c2;
            r_c4     <= r_c3;
        end
    end

    assign o_valid = r_v[3];
    assign o_adot  = r_adot;
    assign o_len2  = r_len2_o;
    assign o_color = r_c4;

endmodule

[hw/rtl/bps_norm.sv]
// ============================================================================
// bps_norm: cosine of the half angle
// Takes the square root of H.H one result bit per stage, then divides
// 2*|H.N| by it one quotient bit per stage, clamps the result to one, and gives zero when H.H is zero.
// ============================================================================
module bps_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bps_pkg::t_flow i_flow,
    input  logic [32:0]    i_adot,
    input  logic [33:0]    i_len2,
    input  bps_pkg::t_rgb  i_color,
    output logic           o_valid,
    output logic [15:0]    o_u,
    output bps_pkg::t_rgb  o_color
);

    localparam int NSQ = 17;
    localparam int NDV = 17;

    typedef struct packed {
        logic [33:0] n;
        logic [34:0] r;
    } t_sq;

    typedef struct packed {
        logic [16:0] rem;
        logic [16:0] low;
        logic [16:0] q;
    } t_dv;

    function automatic t_sq sq_step(input t_sq x, input int s);
        t_sq         y;
        logic [34:0] b;
        logic [34:0] t;
        b = 35'd1 << (32 - 2 * s);
        t = x.r + b;
        if ({1'b0, x.n} >= t) begin
            y.n = x.n - t[33:0];
            y.r = (x.r >> 1) + b;
        end else begin
            y.n = x.n;
            y.r = x.r >> 1;
        end
        return y;
    endfunction

    function automatic t_dv dv_step(input t_dv x, input logic [16:0] h);
        t_dv         y;
        logic [17:0] t;
        t = {x.rem, x.low[16]};
        if (t >= {1'b0, h}) begin
            y.rem = 17'(t - {1'b0, h});
            y.q   = {x.q[15:0], 1'b1};
        end else begin
            y.rem = t[16:0];
            y.q   = {x.q[15:0], 1'b0};
        end
        y.low = {x.low[15:0], 1'b0};
        return y;
    endfunction

    logic [NSQ-1:0] r_sv;
    t_sq            r_sq [NSQ];
    logic [32:0]    r_sa [NSQ];
    bps_pkg::t_rgb  r_sc [NSQ];
    t_sq            n_sq [NSQ];

    logic           r_d_v;
    t_dv            r_d;
    logic [16:0]    r_d_h;
    logic           r_d_big;
    logic           r_d_zero;
    bps_pkg::t_rgb  r_d_c;

    logic [NDV-1:0] r_qv;
    t_dv            r_q [NDV];
    logic [16:0]    r_qh [NDV];
    logic           r_qb [NDV];
    logic           r_qz [NDV];
    bps_pkg::t_rgb  r_qc [NDV];
    t_dv            n_q [NDV];

    logic           r_uv;
    logic [15:0]    r_u;
    bps_pkg::t_rgb  r_uc;

    logic [16:0]    hlen;
    logic [33:0]    num;

    assign hlen = r_sq[NSQ-1].r[16:0];
    assign num  = {r_sa[NSQ-1], 1'b0};

    always_comb begin
        n_sq[0] = sq_step('{n: i_len2, r: 35'd0}, 0);
        for (int s = 1; s < NSQ; s++) begin
            n_sq[s] = sq_step(r_sq[s-1], s);
        end
        n_q[0] = dv_step(r_d, r_d_h);
        for (int s = 1; s < NDV; s++) begin
            n_q[s] = dv_step(r_q[s-1], r_qh[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= '0;
            r_d_v <= 1'b0;
            r_qv  <= '0;
            r_uv  <= 1'b0;
        end else if (i_flow.en) begin
            r_sv  <= {r_sv[NSQ-2:0], i_flow.valid};
            r_d_v <= r_sv[NSQ-1];
            r_qv  <= {r_qv[NDV-2:0], r_d_v};
            r_uv  <= r_qv[NDV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            r_sq[0] <= n_sq[0];
            r_sa[0] <= i_adot;
            r_sc[0] <= i_color;
            for (int s = 1; s < NSQ; s++) begin
                r_sq[s] <= n_sq[s];
                r_sa[s] <= r_sa[s-1];
                r_sc[s] <= r_sc[s-1];
            end

            r_d.rem  <= num[33:17];
            r_d.low  <= num[16:0];
            r_d.q    <= '0;
            r_d_h    <= hlen;
            r_d_big  <= num[33:17] >= hlen;
            r_d_zero <= hlen == 17'd0;
            r_d_c    <= r_sc[NSQ-1];

            r_q[0]  <= n_q[0];
            r_qh[0] <= r_d_h;
            r_qb[0] <= r_d_big;
            r_qz[0] <= r_d_zero;
            r_qc[0] <= r_d_c;
            for (int s = 1; s < NDV; s++) begin
                r_q[s]  <= n_q[s];
                r_qh[s] <= r_qh[s-1];
                r_qb[s] <= r_qb[s-1];
                r_qz[s] <= r_qz[s-1];
                r_qc[s] <= r_qc[s-1];
            end

            if (r_qz[NDV-1]) begin
                r_u <= 16'd0;
            end else if (r_qb[NDV-1] || r_q[NDV-1].q > 17'(bps_pkg::ONE_Q15)) begin
                r_u <= bps_pkg::ONE_Q15;
            end else begin
                r_u <= r_q[NDV-1].q[15:0];
            end
            r_uc <= r_qc[NDV-1];
        end
    end

    assign o_valid = r_uv;
    assign o_u     = r_u;
    assign o_color = r_uc;

endmodule

[hw/rtl/bps_table.sv]
// ============================================================================
// bps_table: power table
// Builds T[i] = (i/DEPTH)^exponent into a memory with a small sequencer,
// squaring for the integer exponent bits and taking bit-serial square roots
// for the fractional bits, and serves two registered reads per cycle while i_en is high.
// ============================================================================
module bps_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [15:0]                i_exponent,
    input  logic                       i_en,
    input  logic [bps_pkg::ADDR_W-1:0] i_addr_a,
    input  logic [bps_pkg::ADDR_W-1:0] i_addr_b,
    output logic [15:0]                o_data_a,
    output logic [15:0]                o_data_b,
    output logic                       o_busy
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_INT  = 3'd2;
    localparam logic [2:0] ST_SQLD = 3'd3;
    localparam logic [2:0] ST_SQ   = 3'd4;
    localparam logic [2:0] ST_FMUL = 3'd5;
    localparam logic [2:0] ST_WR   = 3'd6;

    logic [15:0]                r_mem [bps_pkg::POW_TABLE_DEPTH + 1];
    logic [15:0]                r_rd_a;
    logic [15:0]                r_rd_b;

    logic [2:0]                 r_state;
    logic [bps_pkg::ADDR_W-1:0] r_ent;
    logic [2:0]                 r_k;
    logic [15:0]                r_acc;
    logic [15:0]                r_base;
    logic [15:0]                r_root;
    logic [30:0]                r_sn;
    logic [31:0]                r_sr;
    logic [30:0]                r_sbit;
    logic [3:0]                 r_sj;

    logic [15:0]                x;
    logic [31:0]                st;
    logic [7:0]                 e_int;
    logic [7:0]                 e_frac;

    assign x      = 16'(r_ent) << (15 - bps_pkg::POW_DEPTH_LOG2);
    assign st     = r_sr + {1'b0, r_sbit};
    assign e_int  = i_exponent[15:8];
    assign e_frac = i_exponent[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ent   <= '0;
        end else if (i_start) begin
            r_state <= ST_INIT;
            r_ent   <= '0;
        end else begin
            case (r_state)
                ST_INIT: begin
                    r_state <= ST_INT;
                end
                ST_INT: begin
                    if (r_k == 3'd7) begin
                        r_state <= ST_SQLD;
                    end
                end
                ST_SQLD: begin
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    if (r_sj == 4'd15) begin
                        r_state <= ST_FMUL;
                    end
                end
                ST_FMUL: begin
                    r_state <= (r_k == 3'd7) ? ST_WR : ST_SQLD;
                end
                ST_WR: begin
                    if (r_ent == bps_pkg::ADDR_W'(bps_pkg::POW_TABLE_DEPTH)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_ent   <= r_ent + 1'b1;
                        r_state <= ST_INIT;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_INIT: begin
                r_acc  <= bps_pkg::ONE_Q15;
                r_base <= x;
                r_root <= x;
                r_k    <= 3'd0;
            end
            ST_INT: begin
                if (e_int[r_k]) begin
                    r_acc <= bps_pkg::mulq15(r_acc, r_base);
                end
                r_base <= bps_pkg::mulq15(r_base, r_base);
                r_k    <= r_k + 1'b1;
            end
            ST_SQLD: begin
                r_sn   <= {r_root, 15'd0};
                r_sr   <= 32'd0;
                r_sbit <= 31'd1 << 30;
                r_sj   <= 4'd0;
            end
            ST_SQ: begin
                if ({1'b0, r_sn} >= st) begin
                    r_sn <= r_sn - st[30:0];
                    r_sr <= (r_sr >> 1) + {1'b0, r_sbit};
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
                r_sj   <= r_sj + 1'b1;
            end
            ST_FMUL: begin
                r_root <= r_sr[15:0];
                if (e_frac[3'd7 - r_k]) begin
                    r_acc <= bps_pkg::mulq15(r_acc, r_sr[15:0]);
                end
                r_k <= r_k + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WR) begin
            r_mem[r_ent] <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_a <= r_mem[i_addr_a];
            r_rd_b <= r_mem[i_addr_b];
        end
    end

    assign o_data_a = r_rd_a;
    assign o_data_b = r_rd_b;
    assign o_busy   = r_state != ST_IDLE;

endmodule

[hw/rtl/bps_shade.sv]
// ============================================================================
// bps_shade: specular color
// Interpolates the power table, forms the Schlick factor, blends the material
// color if fresnel is on, scales by intensity and light color with saturation.
// ============================================================================
module bps_shade (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bps_pkg::t_flow             i_flow,
    input  logic [15:0]                i_u,
    input  bps_pkg::t_rgb              i_color,
    input  bps_pkg::t_cfg              i_cfg,
    input  logic [15:0]                i_tab_a,
    input  logic [15:0]                i_tab_b,
    output logic [bps_pkg::ADDR_W-1:0] o_addr_a,
    output logic [bps_pkg::ADDR_W-1:0] o_addr_b,
    output logic                       o_valid,
    output bps_pkg::t_res              o_res
);

    localparam int SW = 16 + bps_pkg::POW_DEPTH_LOG2;
    localparam int NST = 9;

    logic [SW-1:0]              sc;
    logic [bps_pkg::ADDR_W-1:0] idx;
    logic [14:0]                frac;
    logic signed [33:0]         sum;
    logic [48:0]                rnd [3];
    logic [15:0]                cl [3];
    logic                       dis;

    logic [NST-1:0]     r_v;
    logic [15:0]        r_s1_u;
    logic [14:0]        r_s1_frac;
    bps_pkg::t_rgb      r_s1_c;
    logic [15:0]        r_s2_a;
    logic signed [32:0] r_s2_d;
    logic [15:0]        r_s2_f;
    logic [15:0]        r_s2_ff;
    bps_pkg::t_rgb      r_s2_c;
    logic [15:0]        r_s3_spec;
    logic [15:0]        r_s3_f;
    logic [15:0]        r_s3_ff2;
    bps_pkg::t_rgb      r_s3_c;
    logic [15:0]        r_s4_spec;
    logic [15:0]        r_s4_f5;
    bps_pkg::t_rgb      r_s4_c;
    logic [15:0]        r_s5_spec;
    logic [15:0]        r_s5_cs [3];
    bps_pkg::t_rgb      r_s5_c;
    logic [15:0]        r_s6_m [3];
    bps_pkg::t_rgb      r_s6_c;
    logic [31:0]        r_s7_p [3];
    bps_pkg::t_rgb      r_s7_c;
    logic [47:0]        r_s8_p [3];
    bps_pkg::t_res      r_s9_res;

    assign sc       = {i_u, {bps_pkg::POW_DEPTH_LOG2{1'b0}}};
    assign idx      = sc[SW-1:15];
    assign frac     = sc[14:0];
    assign o_addr_a = idx;
    assign o_addr_b = (idx == bps_pkg::ADDR_W'(bps_pkg::POW_TABLE_DEPTH)) ? idx : idx + 1'b1;

    assign sum = $signed({3'b000, r_s2_a, 15'd0}) + r_s2_d;
    assign dis = (i_cfg.exponent == 16'd0) || (i_cfg.intensity == 16'd0);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cl[k]  = (i_cfg.color[k] > bps_pkg::ONE_Q15) ? bps_pkg::ONE_Q15 : i_cfg.color[k];
            rnd[k] = {1'b0, r_s8_p[k]} + (49'd1 << 26);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_flow.en) begin
            r_v <= {r_v[NST-2:0], i_flow.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            r_s1_u    <= i_u;
            r_s1_frac <= frac;
            r_s1_c    <= i_color;

            r_s2_a  <= i_tab_a;
            r_s2_d  <= ($signed({1'b0, i_tab_b}) - $signed({1'b0, i_tab_a}))
                     * $signed({1'b0, r_s1_frac});
            r_s2_f  <= bps_pkg::ONE_Q15 - r_s1_u;
            r_s2_ff <= bps_pkg::mulq15(bps_pkg::ONE_Q15 - r_s1_u,
                                       bps_pkg::ONE_Q15 - r_s1_u);
            r_s2_c  <= r_s1_c;

            r_s3_spec <= sum[30:15];
            r_s3_f    <= r_s2_f;
            r_s3_ff2  <= bps_pkg::mulq15(r_s2_ff, r_s2_ff);
            r_s3_c    <= r_s2_c;

            r_s4_spec <= r_s3_spec;
            r_s4_f5   <= bps_pkg::mulq15(r_s3_f, r_s3_ff2);
            r_s4_c    <= r_s3_c;

            r_s5_spec <= r_s4_spec;
            r_s5_c    <= r_s4_c;
            r_s6_c    <= r_s5_c;
            r_s7_c    <= r_s6_c;
            for (int k = 0; k < 3; k++) begin
                r_s5_cs[k] <= i_cfg.fresnel
                            ? cl[k] + bps_pkg::mulq15(bps_pkg::ONE_Q15 - cl[k], r_s4_f5)
                            : cl[k];
                r_s6_m[k]  <= bps_pkg::mulq15(r_s5_cs[k], r_s5_spec);
                r_s7_p[k]  <= {16'd0, r_s6_m[k]} * {16'd0, i_cfg.intensity};
                r_s8_p[k]  <= {16'd0, r_s7_p[k]} * {32'd0, r_s7_c[k]};
            end

            r_s9_res.spec_valid <= !dis;
            for (int k = 0; k < 3; k++) begin
                if (dis) begin
                    r_s9_res.color[k] <= 16'd0;
                end else if (|rnd[k][48:43]) begin
                    r_s9_res.color[k] <= 16'hFFFF;
                end else begin
                    r_s9_res.color[k] <= rnd[k][42:27];
                end
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_res   = r_s9_res;

endmodule

[hw/rtl/blinn_phong_specular.sv]
// ============================================================================
// blinn_phong_specular: Blinn-Phong specular term with Schlick fresnel
// Fixed-point specular shader: half vector, cosine, table power, optional
// fresnel blend and color scaling, as one stallable pipeline.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_ready    normal, light, view, light color
//   output    out        o_valid / i_ready    spec_valid, out color
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One word is accepted per cycle while o_ready is high.
// Most of the pipeline's stages are in the bit-per-stage square root and divider.
// After reset and after each write of the exponent register the power table
// is rebuilt, during which o_ready is low.
// The pipeline stalls as a whole only when its two-word output buffer is full.
// ============================================================================
module blinn_phong_specular (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [15:0]                   i_normal_x,
    input  logic [15:0]                   i_normal_y,
    input  logic [15:0]                   i_normal_z,
    input  logic [15:0]                   i_light_x,
    input  logic [15:0]                   i_light_y,
    input  logic [15:0]                   i_light_z,
    input  logic [15:0]                   i_view_x,
    input  logic [15:0]                   i_view_y,
    input  logic [15:0]                   i_view_z,
    input  logic [15:0]                   i_light_red,
    input  logic [15:0]                   i_light_green,
    input  logic [15:0]                   i_light_blue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_spec_valid,
    output logic [15:0]                   o_out_red,
    output logic [15:0]                   o_out_green,
    output logic [15:0]                   o_out_blue,
    input  logic                          i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_data
);

    bps_pkg::t_cfg   r_cfg;
    bps_pkg::t_flow  flow;
    logic            en;
    logic            busy;

    logic            vec_valid;
    logic [32:0]     vec_adot;
    logic [33:0]     vec_len2;
    bps_pkg::t_rgb   vec_color;
    bps_pkg::t_flow  norm_flow;

    logic            norm_valid;
    logic [15:0]     norm_u;
    bps_pkg::t_rgb   norm_color;
    bps_pkg::t_flow  shade_flow;

    logic [bps_pkg::ADDR_W-1:0] addr_a;
    logic [bps_pkg::ADDR_W-1:0] addr_b;
    logic [15:0]     tab_a;
    logic [15:0]     tab_b;

    logic            shade_valid;
    bps_pkg::t_res   shade_res;

    logic [1:0]      r_cnt;
    bps_pkg::t_res   r_buf0;
    bps_pkg::t_res   r_buf1;
    logic            push;
    logic            pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exponent  <= 16'd0;
            r_cfg.intensity <= 16'd0;
            r_cfg.color     <= {3{bps_pkg::ONE_Q15}};
            r_cfg.fresnel   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bps_pkg::CFG_SPEC_EXPONENT:    r_cfg.exponent  <= i_cfg_data;
                bps_pkg::CFG_SPEC_INTENSITY:   r_cfg.intensity <= i_cfg_data;
                bps_pkg::CFG_SPEC_COLOR_RED:   r_cfg.color[0]  <= i_cfg_data;
                bps_pkg::CFG_SPEC_COLOR_GREEN: r_cfg.color[1]  <= i_cfg_data;
                bps_pkg::CFG_SPEC_COLOR_BLUE:  r_cfg.color[2]  <= i_cfg_data;
                bps_pkg::CFG_FRESNEL_ENABLE:   r_cfg.fresnel   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign en         = r_cnt != 2'd2;
    assign o_ready    = en && !busy;
    assign flow.en    = en;
    assign flow.valid = i_valid && o_ready;

    assign norm_flow.en     = en;
    assign norm_flow.valid  = vec_valid;
    assign shade_flow.en    = en;
    assign shade_flow.valid = norm_valid;

    bps_vec u_vec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flow   (flow),
        .i_normal ({i_normal_z, i_normal_y, i_normal_x}),
        .i_light  ({i_light_z, i_light_y, i_light_x}),
        .i_view   ({i_view_z, i_view_y, i_view_x}),
        .i_color  ({i_light_blue, i_light_green, i_light_red}),
        .o_valid  (vec_valid),
        .o_adot   (vec_adot),
        .o_len2   (vec_len2),
        .o_color  (vec_color)
    );

    bps_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flow   (norm_flow),
        .i_adot   (vec_adot),
        .i_len2   (vec_len2),
        .i_color  (vec_color),
        .o_valid  (norm_valid),
        .o_u      (norm_u),
        .o_color  (norm_color)
    );

    bps_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cfg_we && (i_cfg_idx == bps_pkg::CFG_SPEC_EXPONENT)),
        .i_exponent (r_cfg.exponent),
        .i_en       (en),
        .i_addr_a   (addr_a),
        .i_addr_b   (addr_b),
        .o_data_a   (tab_a),
        .o_data_b   (tab_b),
        .o_busy     (busy)
    );

    bps_shade u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flow   (shade_flow),
        .i_u      (norm_u),
        .i_color  (norm_color),
        .i_cfg    (r_cfg),
        .i_tab_a  (tab_a),
        .i_tab_b  (tab_b),
        .o_addr_a (addr_a),
        .o_addr_b (addr_b),
        .o_valid  (shade_valid),
        .o_res    (shade_res)
    );

    assign push = en && shade_valid;
    assign pop  = (r_cnt != 2'd0) && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_buf0 <= (push && r_cnt == 2'd1) ? shade_res : r_buf1;
            if (push && r_cnt == 2'd2) begin
                r_buf1 <= shade_res;
            end
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_buf0 <= shade_res;
            end else begin
                r_buf1 <= shade_res;
            end
        end
    end

    assign o_valid      = r_cnt != 2'd0;
    assign o_spec_valid = r_buf0.spec_valid;
    assign o_out_red    = r_buf0.color[0];
    assign o_out_green  = r_buf0.color[1];
    assign o_out_blue   = r_buf0.color[2];

    a_no_accept_while_building: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) busy |-> !o_ready
    ) else $error("word accepted while the power table is being built");

    a_frozen_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt == 2'd2) |-> !o_ready
    ) else $error("word accepted while the output buffer is full");

    a_count_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3
    ) else $error("output buffer overflow");

    a_full_holds_push: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt == 2'd2 && !i_ready) |=> (r_cnt == 2'd2)
    ) else $error("output buffer changed while stalled");

endmodule
